FILE: design/dtce_pkg.sv
// Shared types, constants and the code-mapping function for the dead-time code encoder.
// Used by dtce_div_stage and dead_time_code_encoder; depends on nothing.
package dtce_pkg;

    localparam int unsigned T_W        = 24;    // request width, ns
    localparam int unsigned P_W        = 12;    // period width, ns
    localparam int unsigned Q_W        = 10;    // quotient bits below the saturation bound
    localparam int unsigned D_W        = P_W + Q_W - 1;  // widest shifted divisor
    localparam int unsigned DIV_STAGES = Q_W;   // one quotient bit per stage
    localparam int unsigned CODE_W     = 8;

    localparam logic [P_W-1:0]    PERIOD_RESET = 12'd6;
    localparam logic [CODE_W-1:0] CODE_SAT     = 8'hFF;

    localparam logic [0:0] PFX_R1 = 1'b0;
    localparam logic [1:0] PFX_R2 = 2'b10;
    localparam logic [2:0] PFX_R3 = 3'b110;
    localparam logic [2:0] PFX_R4 = 3'b111;

    // One item in flight through the divider.
    typedef struct packed {
        logic [T_W-1:0] rem;   // partial remainder
        logic [D_W-1:0] dvs;   // divisor aligned to the current quotient bit
        logic [Q_W-1:0] quo;   // quotient bits found so far
        logic           sat;   // request lies above the fourth range
    } t_div_item;

    // Map quotient t/p to the range prefix plus step count.
    function automatic logic [CODE_W-1:0] encode_code(input logic [Q_W-1:0] q,
                                                      input logic sat);
        logic [CODE_W-1:0] code;
        begin
            if (sat) begin
                code = CODE_SAT;
            end else if (q[9:7] == 3'd0) begin
                code = {PFX_R1, q[6:0]};
            end else if (q[9:8] == 2'd0) begin
                code = {PFX_R2, q[6:1]};
            end else if (!q[9]) begin
                code = {PFX_R3, q[7:3]};
            end else begin
                code = {PFX_R4, q[8:4]};
            end
            encode_code = code;
        end
    endfunction

endpackage

FILE: design/dtce_div_stage.sv
// One restoring-division step with its own pipeline register and handshake.
// Depends on dtce_pkg for the item struct.
module dtce_div_stage
    import dtce_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_item i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_item o_item
);

    logic      r_vld;
    t_div_item r_item;
    t_div_item n_item;
    logic      w_load;
    logic      w_ge;
    logic [T_W-1:0] w_dvs_ext;

    assign w_load    = !r_vld || i_ready;
    assign o_ready   = w_load;
    assign w_dvs_ext = {{(T_W-D_W){1'b0}}, i_item.dvs};
    // A zero divisor (zero period) never fits, so a zero request keeps a zero quotient.
    assign w_ge      = (i_item.dvs != '0) && (i_item.rem >= w_dvs_ext);

    // Subtract when the aligned divisor fits, shift in the quotient bit.
    always_comb begin
        n_item     = i_item;
        n_item.rem = w_ge ? (i_item.rem - w_dvs_ext) : i_item.rem;
        n_item.quo = {i_item.quo[Q_W-2:0], w_ge};
        n_item.dvs = i_item.dvs >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

FILE: design/dead_time_code_encoder.sv
// Top level of the dead-time code encoder: entry stage, divider chain, code output register.
// Depends on dtce_pkg and dtce_div_stage.
//
//  channel   | direction | transaction carries
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tdata[23:0] dead_time_ns
//  m_axis    | out       | tdata[7:0] dtg_code, tuser[0] saturated
//  cfg       | in        | i_cfg_data[11:0] clock_period_ns (always ready)
//
// Takes one transaction per cycle unless m_axis stalls. The path is an
// entry stage that checks the saturation bound, ten restoring-division
// stages (one quotient bit each, one 24-bit compare/subtract per stage),
// and the output register that holds the encoded byte.
// Each stage has its own valid bit and loads when empty or when the stage
// after it moves, so bubbles close up and a stall loses or repeats nothing.
// Reset (synchronous, active low) empties every stage and sets the period to 6 ns.
module dead_time_code_encoder
    import dtce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [T_W-1:0]    s_axis_tdata,    // [23:0] dead_time_ns
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [CODE_W-1:0] m_axis_tdata,    // [7:0] dtg_code
    output logic [0:0]        m_axis_tuser,    // [0] saturated
    // period register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [P_W-1:0]    i_cfg_data       // [11:0] clock_period_ns
);

    logic [P_W-1:0] r_period;

    // Stage chain: index 0 is the entry register, 1..DIV_STAGES the divider steps.
    logic      w_vld  [0:DIV_STAGES];
    logic      w_rdy  [0:DIV_STAGES];
    t_div_item w_item [0:DIV_STAGES];

    logic      r_in_vld;
    t_div_item r_in_item;
    t_div_item n_in_item;
    logic      w_in_load;

    logic              r_out_vld;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_sat;
    logic              w_out_load;

    // ------------------------------------------------------------------
    // Period register; the user must make writes only while the pipeline is empty,
    // the block does not enforce it. -----------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Entry stage: saturate when t >= 1024p, i.e. t[23:10] >= p. A zero
    // period saturates every nonzero request; a zero request never does.
    // Align the divisor to the top quotient bit.
    // ------------------------------------------------------------------
    assign w_in_load     = !r_in_vld || w_rdy[0];
    assign s_axis_tready = w_in_load;

    always_comb begin
        n_in_item.rem = s_axis_tdata;
        n_in_item.dvs = {r_period, {(Q_W-1){1'b0}}};
        n_in_item.quo = '0;
        n_in_item.sat = (s_axis_tdata != '0)
                     && (s_axis_tdata[T_W-1:Q_W] >= {{(T_W-Q_W-P_W){1'b0}}, r_period});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_load) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && s_axis_tvalid) begin
            r_in_item <= n_in_item;
        end
    end

    assign w_vld[0]  = r_in_vld;
    assign w_item[0] = r_in_item;

    // ------------------------------------------------------------------
    // Divider chain: one quotient bit per stage, most significant first.
    // ------------------------------------------------------------------
    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        dtce_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g-1]),
            .o_ready (w_rdy[g-1]),
            .i_item  (w_item[g-1]),
            .o_valid (w_vld[g]),
            .i_ready (w_rdy[g]),
            .o_item  (w_item[g])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: map the quotient to prefix plus step count, all ones
    // if saturated, and hold it until the downstream side takes it.
    // ------------------------------------------------------------------
    assign w_out_load         = !r_out_vld || m_axis_tready;
    assign w_rdy[DIV_STAGES]  = w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= w_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && w_vld[DIV_STAGES]) begin
            r_out_code <= encode_code(w_item[DIV_STAGES].quo, w_item[DIV_STAGES].sat);
            r_out_sat  <= w_item[DIV_STAGES].sat;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out_code;
    assign m_axis_tuser[0] = r_out_sat;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // A saturated result always carries the all-ones code.
    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == CODE_SAT))
        else $error("saturated result without all-ones code");

    // With the output empty, the ready chain must reach the input.
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage is empty");

    // Reset restores the default period.
    a_period_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_period == PERIOD_RESET))
        else $error("period not restored by reset");

endmodule
